>>> rtl/core/bfsf_pkg.sv
`timescale 1ns / 1ps

package bfsf_pkg;

  localparam int DEPTH         = 256;
  localparam int MAX_READ      = 8;
  localparam int PTR_W         = $clog2(DEPTH);
  localparam int DATA_W        = 8;
  localparam int KIND_W        = 3;
  localparam int LEN_W         = 4;
  localparam int LEVEL_W       = 8;
  localparam int TMO_W         = 8;
  localparam int AGE_W         = 8;
  localparam int REM_W         = $clog2(MAX_READ + 1);
  localparam int CMP_W0        = (PTR_W > LEN_W) ? PTR_W : LEN_W;
  localparam int CMP_W         = (CMP_W0 > REM_W) ? CMP_W0 : REM_W;
  localparam int LVX_W         = (PTR_W > LEVEL_W) ? PTR_W : LEVEL_W;

  localparam logic [TMO_W-1:0]   TIMEOUT_RESET = TMO_W'(30);
  localparam logic [AGE_W-1:0]   AGE_MAX       = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = '1;

  localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRE  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic               valid;
    logic               ok;
    logic               last;
    logic               from_ram;
    logic [LEVEL_W-1:0] level;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  function automatic logic [PTR_W-1:0] held(input logic [PTR_W-1:0] w,
                                            input logic [PTR_W-1:0] r);
    logic [PTR_W:0] s;
    if (w >= r) begin
      s = {1'b0, w} - {1'b0, r};
    end else begin
      s = {1'b0, w} + (PTR_W+1)'(DEPTH) - {1'b0, r};
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [LEVEL_W-1:0] sat_level(input logic [PTR_W-1:0] h);
    logic [LVX_W-1:0] x;
    logic [LEVEL_W-1:0] l;
    x = LVX_W'(h);
    l = (x > LVX_W'(LEVEL_MAX)) ? LEVEL_MAX : x[LEVEL_W-1:0];
    return l;
  endfunction

endpackage

>>> rtl/core/byte_fifo_with_stale_flush_core.sv
// results come the cycle after their item is taken; read bytes also pass state and ram regs
// push, tick, discard, expiry, zero-length and refused reads: one item per cycle while not busy
// granted read of n bytes: busy while its bytes are read, one byte per cycle from the byte ram
// the receiver cannot stall; results are strobed for one cycle
// synchronous active-low reset: fifo empty, age zero, timeout 30; byte ram not cleared
`timescale 1ns / 1ps

module byte_fifo_with_stale_flush_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bfsf_pkg::KIND_W-1:0]    in_kind,
  input  logic [bfsf_pkg::DATA_W-1:0]    in_data_in,
  input  logic [bfsf_pkg::LEN_W-1:0]     in_read_length,
  input  logic                           cfg_we,
  input  logic [bfsf_pkg::TMO_W-1:0]     cfg_wdata,
  output logic                           out_valid,
  output logic                           out_ok,
  output logic [bfsf_pkg::DATA_W-1:0]    out_data_out,
  output logic                           out_last,
  output logic [bfsf_pkg::LEVEL_W-1:0]   out_level
);
  import bfsf_pkg::*;

  ram_req_t          ram_req;
  res_t              res;
  logic [DATA_W-1:0] ram_q;

  bfsf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_data_in     (in_data_in),
    .in_read_length (in_read_length),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .ram_req        (ram_req),
    .res            (res)
  );

  bfsf_ram #(
    .AW    (PTR_W),
    .DW    (DATA_W),
    .WORDS (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_q)
  );

  assign out_valid    = res.valid;
  assign out_ok       = res.ok;
  assign out_last     = res.last;
  assign out_level    = res.level;
  assign out_data_out = res.from_ram ? ram_q : '0;

endmodule

>>> rtl/core/bfsf_ram.sv
`timescale 1ns / 1ps

module bfsf_ram #(
  parameter int AW    = 8,
  parameter int DW    = 8,
  parameter int WORDS = 256
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [WORDS];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bfsf_ctrl.sv
`timescale 1ns / 1ps

module bfsf_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bfsf_pkg::KIND_W-1:0]   in_kind,
  input  logic [bfsf_pkg::DATA_W-1:0]   in_data_in,
  input  logic [bfsf_pkg::LEN_W-1:0]    in_read_length,
  input  logic                          cfg_we,
  input  logic [bfsf_pkg::TMO_W-1:0]    cfg_wdata,
  output bfsf_pkg::ram_req_t            ram_req,
  output bfsf_pkg::res_t                res
);
  import bfsf_pkg::*;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic [TMO_W-1:0] tmo_r;
  logic [REM_W-1:0] rem_r, rem_nxt;
  res_t             res_r, res_nxt;

  logic             accept;
  logic [PTR_W-1:0] held_now;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] held_ext;

  assign accept   = start && (state_r == ST_IDLE);
  assign held_now = held(wp_r, rp_r);
  assign len_ext  = CMP_W'(in_read_length);
  assign held_ext = CMP_W'(held_now);

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    age_nxt   = age_r;
    rem_nxt   = rem_r;
    res_nxt   = '0;
    ram_req   = '0;
    ram_req.waddr = wp_r;
    ram_req.wdata = in_data_in;
    ram_req.raddr = rp_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt.valid = 1'b1;
          res_nxt.last  = 1'b1;
          case (in_kind)
            KIND_PUSH: begin
              if (ptr_inc(wp_r) != rp_r) begin
                ram_req.we  = 1'b1;
                wp_nxt      = ptr_inc(wp_r);
                age_nxt     = '0;
                res_nxt.ok  = 1'b1;
              end
            end
            KIND_READ: begin
              if (len_ext > CMP_W'(MAX_READ) || held_ext < len_ext) begin
                res_nxt.ok = 1'b0;
              end else if (len_ext == '0) begin
                res_nxt.ok = 1'b1;
              end else begin
                // granted: results come from the read sequencer
                res_nxt   = '0;
                rem_nxt   = len_ext[REM_W-1:0];
                state_nxt = ST_READ;
              end
            end
            KIND_TICK: begin
              if (age_r != AGE_MAX) begin
                age_nxt = age_r + 1'b1;
              end
            end
            KIND_DISCARD: begin
              rp_nxt = wp_r;
            end
            KIND_EXPIRE: begin
              if (held_now != '0 && age_r > tmo_r) begin
                rp_nxt     = wp_r;
                res_nxt.ok = 1'b1;
              end
            end
            default: begin
              res_nxt.ok = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        ram_req.re       = 1'b1;
        rp_nxt           = ptr_inc(rp_r);
        rem_nxt          = rem_r - 1'b1;
        res_nxt.valid    = 1'b1;
        res_nxt.ok       = 1'b1;
        res_nxt.from_ram = 1'b1;
        res_nxt.last     = (rem_r == REM_W'(1));
        if (rem_r == REM_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res_nxt.level = sat_level(held(wp_nxt, rp_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      age_r   <= '0;
      rem_r   <= '0;
      tmo_r   <= TIMEOUT_RESET;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      age_r   <= age_nxt;
      rem_r   <= rem_nxt;
      res_r   <= res_nxt;
      if (cfg_we) begin
        tmo_r <= cfg_wdata;
      end
    end
  end

  assign busy = (state_r == ST_READ);
  assign res  = res_r;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import bfsf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 60;

  localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_C = 3'd7;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  dout;
    logic               last;
    logic [LEVEL_W-1:0] level;
  } fifo_result_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              typed;
    fifo_result_t      want;
  } dir_row_t;

  // directed rows; typed rows carry their one result, the rest use the predictor
  localparam dir_row_t DIR_ROWS [25] = '{
    '{KIND_EXPIRE,   8'h00, 4'd0,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd0}},
    '{KIND_READ,     8'h00, 4'd1,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd0}},
    '{KIND_READ,     8'h00, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd0}},
    '{KIND_TICK,     8'h00, 4'd0,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd0}},
    '{KIND_UNUSED_A, 8'hff, 4'd15, 1'b1, '{1'b0, 8'h00, 1'b1, 8'd0}},
    '{KIND_PUSH,     8'h00, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd1}},
    '{KIND_PUSH,     8'hff, 4'd15, 1'b1, '{1'b1, 8'h00, 1'b1, 8'd2}},
    '{KIND_PUSH,     8'ha5, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd3}},
    '{KIND_PUSH,     8'h5a, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd4}},
    '{KIND_READ,     8'h00, 4'd9,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd4}},
    '{KIND_READ,     8'hff, 4'd15, 1'b1, '{1'b0, 8'h00, 1'b1, 8'd4}},
    '{KIND_READ,     8'h00, 4'd5,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd4}},
    '{KIND_READ,     8'h00, 4'd2,  1'b0, '{1'b0, 8'h00, 1'b0, 8'd0}},
    '{KIND_UNUSED_B, 8'h00, 4'd0,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd2}},
    '{KIND_UNUSED_C, 8'hff, 4'd8,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd2}},
    '{KIND_DISCARD,  8'h00, 4'd0,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd0}},
    '{KIND_PUSH,     8'h3c, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd1}},
    '{KIND_PUSH,     8'hc3, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd2}},
    '{KIND_PUSH,     8'h0f, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd3}},
    '{KIND_PUSH,     8'hf0, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd4}},
    '{KIND_READ,     8'h00, 4'd4,  1'b0, '{1'b0, 8'h00, 1'b0, 8'd0}},
    '{KIND_PUSH,     8'h81, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd1}},
    '{KIND_TICK,     8'h00, 4'd0,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd1}},
    '{KIND_EXPIRE,   8'h00, 4'd0,  1'b1, '{1'b0, 8'h00, 1'b1, 8'd1}},
    '{KIND_READ,     8'h00, 4'd0,  1'b1, '{1'b1, 8'h00, 1'b1, 8'd1}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [DATA_W-1:0]   in_data_in = '0;
  logic [LEN_W-1:0]    in_read_length = '0;
  logic                cfg_we = 1'b0;
  logic [TMO_W-1:0]    cfg_wdata = '0;
  logic                out_valid;
  logic                out_ok;
  logic [DATA_W-1:0]   out_data_out;
  logic                out_last;
  logic [LEVEL_W-1:0]  out_level;

  // predictor state
  logic [DATA_W-1:0]   mdl_bytes [DEPTH];
  logic [PTR_W-1:0]    mdl_wp = '0;
  logic [PTR_W-1:0]    mdl_rp = '0;
  logic [AGE_W-1:0]    mdl_age = '0;
  logic [TMO_W-1:0]    mdl_timeout = TIMEOUT_RESET;

  fifo_result_t        step_results [$];
  fifo_result_t        pending_results [$];

  logic                row_typed = 1'b0;
  fifo_result_t        row_want = '0;
  logic                took = 1'b0;
  int unsigned         burst_left = 0;
  int                  err_count = 0;
  int                  cycle_count = 0;

  byte_fifo_with_stale_flush_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_data_in     (in_data_in),
    .in_read_length (in_read_length),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_data_out   (out_data_out),
    .out_last       (out_last),
    .out_level      (out_level)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    return (int'(p) == DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic int fifo_fill();
    return (int'(mdl_wp) + DEPTH - int'(mdl_rp)) % DEPTH;
  endfunction

  function automatic void add_result(input logic ok, input logic [DATA_W-1:0] d,
                                     input logic last);
    fifo_result_t r;
    int lv;
    lv = fifo_fill();
    r.ok    = ok;
    r.dout  = d;
    r.last  = last;
    r.level = (lv > 255) ? LEVEL_MAX : LEVEL_W'(lv);
    step_results.push_back(r);
  endfunction

  function automatic void predict_item(input logic [KIND_W-1:0] k,
                                       input logic [DATA_W-1:0] d,
                                       input logic [LEN_W-1:0] n);
    logic [PTR_W-1:0] nxt;
    logic ok;
    step_results.delete();
    case (k)
      KIND_PUSH: begin
        nxt = step_ptr(mdl_wp);
        ok = 1'b0;
        if (nxt != mdl_rp) begin
          mdl_bytes[mdl_wp] = d;
          mdl_wp = nxt;
          mdl_age = '0;
          ok = 1'b1;
        end
        add_result(ok, '0, 1'b1);
      end
      KIND_READ: begin
        if (int'(n) > MAX_READ || fifo_fill() < int'(n)) begin
          add_result(1'b0, '0, 1'b1);
        end else if (n == 0) begin
          add_result(1'b1, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(n); i++) begin
            nxt = mdl_rp;
            mdl_rp = step_ptr(mdl_rp);
            add_result(1'b1, mdl_bytes[nxt], (i == int'(n) - 1));
          end
        end
      end
      KIND_TICK: begin
        if (mdl_age != AGE_MAX) mdl_age = mdl_age + 1'b1;
        add_result(1'b0, '0, 1'b1);
      end
      KIND_DISCARD: begin
        mdl_rp = mdl_wp;
        add_result(1'b0, '0, 1'b1);
      end
      KIND_EXPIRE: begin
        ok = 1'b0;
        if (fifo_fill() != 0 && mdl_age > mdl_timeout) begin
          mdl_rp = mdl_wp;
          ok = 1'b1;
        end
        add_result(ok, '0, 1'b1);
      end
      default: begin
        add_result(1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  // transfer monitor and result checker
  always @(posedge clk) begin
    fifo_result_t e;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("byte_fifo_with_stale_flush_core verification failed");
      $finish;
    end
    took = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, level", out_level, 0);
        end else begin
          e = pending_results.pop_front();
          if (out_ok !== e.ok) report_mismatch("ok", out_ok, e.ok);
          if (out_data_out !== e.dout) report_mismatch("data_out", out_data_out, e.dout);
          if (out_last !== e.last) report_mismatch("last", out_last, e.last);
          if (out_level !== e.level) report_mismatch("level", out_level, e.level);
        end
      end
      if (start && !busy) begin
        took = 1'b1;
        predict_item(in_kind, in_data_in, in_read_length);
        if (row_typed) begin
          pending_results.push_back(row_want);
        end else begin
          foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
      end
      if (cfg_we) mdl_timeout = cfg_wdata;
    end
  end

  // called just after a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] d,
                           input logic [LEN_W-1:0] n, input logic typed,
                           input fifo_result_t want);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    in_kind = k;
    in_data_in = d;
    in_read_length = n;
    row_typed = typed;
    row_want = want;
    start = 1'b1;
    do @(negedge clk); while (!took);
    burst_left--;
  endtask

  task automatic send_plain(input logic [KIND_W-1:0] k, input logic [DATA_W-1:0] d,
                            input logic [LEN_W-1:0] n);
    send_item(k, d, n, 1'b0, '0);
  endtask

  task automatic drain_results();
    start = 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [TMO_W-1:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random();
    int r;
    int h;
    int top;
    logic [DATA_W-1:0] d;
    r = $urandom_range(0, 99);
    h = fifo_fill();
    d = DATA_W'($urandom_range(0, 255));
    if (r < 40) begin
      send_plain(KIND_PUSH, d, LEN_W'($urandom_range(0, 15)));
    end else if (r < 65) begin
      top = (h < MAX_READ) ? h : MAX_READ;
      if (top > 0 && $urandom_range(0, 4) != 0)
        send_plain(KIND_READ, d, LEN_W'($urandom_range(1, top)));
      else
        send_plain(KIND_READ, d, LEN_W'($urandom_range(1, MAX_READ)));
    end else if (r < 80) begin
      send_plain(KIND_TICK, d, LEN_W'($urandom_range(0, 15)));
    end else if (r < 88) begin
      send_plain(KIND_EXPIRE, d, LEN_W'($urandom_range(0, 15)));
    end else if (r < 91) begin
      send_plain(KIND_DISCARD, d, LEN_W'($urandom_range(0, 15)));
    end else if (r < 95) begin
      case ($urandom_range(0, 2))
        0: send_plain(KIND_UNUSED_A, d, LEN_W'($urandom_range(0, 15)));
        1: send_plain(KIND_UNUSED_B, d, LEN_W'($urandom_range(0, 15)));
        default: send_plain(KIND_UNUSED_C, d, LEN_W'($urandom_range(0, 15)));
      endcase
    end else begin
      if ($urandom_range(0, 2) == 0)
        send_plain(KIND_READ, d, '0);
      else
        send_plain(KIND_READ, d, LEN_W'($urandom_range(MAX_READ + 1, 15)));
    end
  endtask

  task automatic random_run(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) drain_results();
      send_random();
    end
  endtask

  // push, let the age run for n ticks, then check expiry
  task automatic age_out(input int n);
    send_plain(KIND_PUSH, DATA_W'($urandom_range(0, 255)), '0);
    repeat (n) send_plain(KIND_TICK, '0, '0);
    send_plain(KIND_EXPIRE, '0, '0);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].kind, DIR_ROWS[i].data, DIR_ROWS[i].len,
                DIR_ROWS[i].typed, DIR_ROWS[i].want);
    random_run(20);
    drain_results();

    set_timeout(TMO_W'(1));
    age_out(2);
    random_run(15);
    drain_results();

    set_timeout('0);
    random_run(15);
    drain_results();

    set_timeout(TMO_W'(254));
    age_out(3);
    random_run(10);
    drain_results();

    set_timeout(AGE_MAX);
    age_out(4);
    random_run(10);
    drain_results();

    set_timeout(TIMEOUT_RESET);
    random_run(20);
    drain_results();

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("byte_fifo_with_stale_flush_core verification clean");
    end else begin
      $display("byte_fifo_with_stale_flush_core verification failed");
    end
    $finish;
  end

endmodule
